/* sv/gbn_pkg.sv */
package gbn_pkg;

  // Sequence space and payload widths
  localparam int unsigned SEQ_MAX     = 7;
  localparam int unsigned SEQ_W       = 3;
  localparam int unsigned BYTE_W      = 8;
  localparam int unsigned STORE_DEPTH = SEQ_MAX + 1;

  typedef logic [SEQ_W-1:0]  seq_t;
  typedef logic [BYTE_W-1:0] byte_t;

  // Event codes on req_type
  typedef enum logic [1:0] {
    REQ_NEW_PACKET = 2'd0,
    REQ_FRAME      = 2'd1,
    REQ_CSUM_ERR   = 2'd2,
    REQ_TIMEOUT    = 2'd3
  } req_e;

  // Controller states
  typedef enum logic {
    ST_IDLE,
    ST_RESEND
  } state_e;

  // Controller to datapath commands
  typedef struct packed {
    logic take_single;  // one-result event, update state and load result
    logic start_resend; // timeout with frames outstanding, load resend pointer
    logic resend_step;  // send one stored frame
  } cmd_t;

  // Datapath to controller status
  typedef struct packed {
    logic resend_needed; // frames outstanding
    logic resend_last;   // current resend slot is the final one
  } stat_t;

  // Advance a sequence number modulo SEQ_MAX+1
  function automatic seq_t seq_inc(input seq_t k);
    seq_inc = (k < seq_t'(SEQ_MAX)) ? seq_t'(k + seq_t'(1)) : seq_t'(0);
  endfunction

  // True when a <= b < c circularly
  function automatic logic in_window(input seq_t a, input seq_t b, input seq_t c);
    in_window = ((a <= b) && (b < c)) || ((c < a) && (a <= b)) || ((b < c) && (c < a));
  endfunction

endpackage

/* sv/go_back_n_window_engine_top.sv */
// Channel   Transaction                    Signals
// ------------------------------------------------------------------------------
// event in  start high while busy low      req_type_i packet_byte_i rx_seq_i
//                                          rx_ack_i rx_byte_i
// result    result_valid_o for one cycle   tx_* deliver_* accept_new_o last_o
//
// A new packet, a frame arrival or a checksum error gives a single result, which
// strobes in the cycle after the event is taken, and busy stays low.
// A timeout with N frames outstanding gives N results: busy is high while the
// resend sequencer reads one frame per cycle from the send buffer's single read
// port; each result is registered from its read.
// Reset (rst_ni low) clears the window pointers and counters at once; the send
// buffer is not cleared. The receiver cannot stall, so results never back up.
module go_back_n_window_engine_top (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       start,
  output logic       busy,
  input  logic [1:0] req_type_i,
  input  logic [7:0] packet_byte_i,
  input  logic [2:0] rx_seq_i,
  input  logic [2:0] rx_ack_i,
  input  logic [7:0] rx_byte_i,
  output logic       result_valid_o,
  output logic       tx_valid_o,
  output logic [2:0] tx_seq_o,
  output logic [2:0] tx_ack_o,
  output logic [7:0] tx_byte_o,
  output logic       deliver_valid_o,
  output logic [7:0] deliver_byte_o,
  output logic       accept_new_o,
  output logic       last_o
);
  import gbn_pkg::*;

  cmd_t  cmd;
  stat_t stat;

  // Sequence events and resend runs
  gbn_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start      (start),
    .req_type_i (req_type_i),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .busy       (busy)
  );

  // Window state, send buffer and result registers
  gbn_datapath u_datapath (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .cmd_i           (cmd),
    .stat_o          (stat),
    .req_type_i      (req_type_i),
    .packet_byte_i   (packet_byte_i),
    .rx_seq_i        (rx_seq_i),
    .rx_ack_i        (rx_ack_i),
    .rx_byte_i       (rx_byte_i),
    .result_valid_o  (result_valid_o),
    .tx_valid_o      (tx_valid_o),
    .tx_seq_o        (tx_seq_o),
    .tx_ack_o        (tx_ack_o),
    .tx_byte_o       (tx_byte_o),
    .deliver_valid_o (deliver_valid_o),
    .deliver_byte_o  (deliver_byte_o),
    .accept_new_o    (accept_new_o),
    .last_o          (last_o)
  );

endmodule

/* sv/gbn_ctrl.sv */
module gbn_ctrl (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           start,
  input  logic [1:0]     req_type_i,
  input  gbn_pkg::stat_t stat_i,
  output gbn_pkg::cmd_t  cmd_o,
  output logic           busy
);
  import gbn_pkg::*;

  state_e state_q, state_d;

  // State register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state and commands
  always_comb begin
    logic take;
    logic is_timeout;
    take       = start && (state_q == ST_IDLE);
    is_timeout = (req_e'(req_type_i) == REQ_TIMEOUT);
    state_d    = state_q;
    cmd_o      = '0;
    busy       = 1'b0;
    unique case (state_q)
      ST_IDLE: begin
        if (take) begin
          if (is_timeout && stat_i.resend_needed) begin
            cmd_o.start_resend = 1'b1;
            state_d            = ST_RESEND;
          end else begin
            cmd_o.take_single = 1'b1;
          end
        end
      end
      ST_RESEND: begin
        busy              = 1'b1;
        cmd_o.resend_step = 1'b1;
        if (stat_i.resend_last) begin
          state_d = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

endmodule

/* sv/gbn_datapath.sv */
module gbn_datapath (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  gbn_pkg::cmd_t  cmd_i,
  output gbn_pkg::stat_t stat_o,
  input  logic [1:0]     req_type_i,
  input  logic [7:0]     packet_byte_i,
  input  logic [2:0]     rx_seq_i,
  input  logic [2:0]     rx_ack_i,
  input  logic [7:0]     rx_byte_i,
  output logic           result_valid_o,
  output logic           tx_valid_o,
  output logic [2:0]     tx_seq_o,
  output logic [2:0]     tx_ack_o,
  output logic [7:0]     tx_byte_o,
  output logic           deliver_valid_o,
  output logic [7:0]     deliver_byte_o,
  output logic           accept_new_o,
  output logic           last_o
);
  import gbn_pkg::*;

  // Protocol state
  seq_t nts_q, nts_d;
  seq_t oldest_q, oldest_d;
  seq_t exp_q, exp_d;
  seq_t count_q, count_d;
  seq_t rptr_q, rptr_d;
  seq_t remain_q, remain_d;

  // Send buffer
  byte_t store_mem [STORE_DEPTH];
  logic  store_we;

  // Result registers
  logic  result_valid_q;
  logic  tx_valid_q, tx_valid_d;
  seq_t  tx_seq_q, tx_seq_d;
  seq_t  tx_ack_q, tx_ack_d;
  byte_t tx_byte_q, tx_byte_d;
  logic  dlv_valid_q, dlv_valid_d;
  byte_t dlv_byte_q, dlv_byte_d;
  logic  accept_q, accept_d;
  logic  last_q, last_d;

  seq_t ack_out;

  assign ack_out = (exp_q == seq_t'(0)) ? seq_t'(SEQ_MAX) : seq_t'(exp_q - seq_t'(1));

  assign stat_o.resend_needed = (count_q != seq_t'(0));
  assign stat_o.resend_last   = (remain_q == seq_t'(1));

  // Decode the event and compute state updates and the result
  always_comb begin
    seq_t span;
    span        = seq_t'(rx_ack_i - oldest_q);
    nts_d       = nts_q;
    oldest_d    = oldest_q;
    exp_d       = exp_q;
    count_d     = count_q;
    rptr_d      = rptr_q;
    remain_d    = remain_q;
    store_we    = 1'b0;
    tx_valid_d  = 1'b0;
    tx_seq_d    = '0;
    tx_ack_d    = '0;
    tx_byte_d   = '0;
    dlv_valid_d = 1'b0;
    dlv_byte_d  = '0;
    last_d      = 1'b1;

    if (cmd_i.take_single) begin
      case (req_e'(req_type_i))
        REQ_NEW_PACKET: begin
          if (count_q < seq_t'(SEQ_MAX)) begin
            store_we   = 1'b1;
            tx_valid_d = 1'b1;
            tx_seq_d   = nts_q;
            tx_ack_d   = ack_out;
            tx_byte_d  = packet_byte_i;
            nts_d      = seq_inc(nts_q);
            count_d    = seq_t'(count_q + seq_t'(1));
          end
        end
        REQ_FRAME: begin
          if (rx_seq_i == exp_q) begin
            dlv_valid_d = 1'b1;
            dlv_byte_d  = rx_byte_i;
            exp_d       = seq_inc(exp_q);
          end
          // free every frame up to and including the acked one
          if ((count_q != seq_t'(0)) && in_window(oldest_q, rx_ack_i, nts_q)) begin
            oldest_d = seq_inc(rx_ack_i);
            count_d  = seq_t'(count_q - span - seq_t'(1));
          end
        end
        default: begin
        end
      endcase
    end

    if (cmd_i.start_resend) begin
      rptr_d   = oldest_q;
      remain_d = count_q;
    end

    if (cmd_i.resend_step) begin
      tx_valid_d = 1'b1;
      tx_seq_d   = rptr_q;
      tx_ack_d   = ack_out;
      last_d     = (remain_q == seq_t'(1));
      rptr_d     = seq_inc(rptr_q);
      remain_d   = seq_t'(remain_q - seq_t'(1));
    end

    accept_d = (count_d < seq_t'(SEQ_MAX));
  end

  // Control and protocol state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nts_q          <= '0;
      oldest_q       <= '0;
      exp_q          <= '0;
      count_q        <= '0;
      rptr_q         <= '0;
      remain_q       <= '0;
      result_valid_q <= 1'b0;
    end else begin
      nts_q          <= nts_d;
      oldest_q       <= oldest_d;
      exp_q          <= exp_d;
      count_q        <= count_d;
      rptr_q         <= rptr_d;
      remain_q       <= remain_d;
      result_valid_q <= cmd_i.take_single || cmd_i.resend_step;
    end
  end

  // Write the send buffer on a new packet
  always_ff @(posedge clk_i) begin
    if (store_we) begin
      store_mem[nts_q] <= packet_byte_i;
    end
  end

  // Load result payload; a resent byte comes straight from the buffer read
  always_ff @(posedge clk_i) begin
    if (cmd_i.resend_step) begin
      tx_byte_q <= store_mem[rptr_q];
    end else if (cmd_i.take_single) begin
      tx_byte_q <= tx_byte_d;
    end
    if (cmd_i.take_single || cmd_i.resend_step) begin
      tx_valid_q  <= tx_valid_d;
      tx_seq_q    <= tx_seq_d;
      tx_ack_q    <= tx_ack_d;
      dlv_valid_q <= dlv_valid_d;
      dlv_byte_q  <= dlv_byte_d;
      accept_q    <= accept_d;
      last_q      <= last_d;
    end
  end

  assign result_valid_o  = result_valid_q;
  assign tx_valid_o      = tx_valid_q;
  assign tx_seq_o        = tx_seq_q;
  assign tx_ack_o        = tx_ack_q;
  assign tx_byte_o       = tx_byte_q;
  assign deliver_valid_o = dlv_valid_q;
  assign deliver_byte_o  = dlv_byte_q;
  assign accept_new_o    = accept_q;
  assign last_o          = last_q;

endmodule

/* dv/tb_top.sv */
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;

  import gbn_pkg::*;

  // One result as it leaves the engine
  typedef struct packed {
    logic  tx_valid;
    seq_t  tx_seq;
    seq_t  tx_ack;
    byte_t tx_byte;
    logic  deliver_valid;
    byte_t deliver_byte;
    logic  accept_new;
    logic  last;
  } engine_result_t;

  // One event, with its result typed in where it is obvious
  typedef struct packed {
    req_e           req;
    byte_t          pkt;
    seq_t           rseq;
    seq_t           rack;
    byte_t          rbyte;
    logic           typed;
    engine_result_t want;
  } event_row_t;

  localparam int unsigned RANDOM_EVENTS = 160;
  localparam int unsigned CALM_TAIL     = 40;
  localparam int unsigned CYCLE_LIMIT   = 200000;
  localparam int unsigned MAX_REPORTS   = 10;

  localparam engine_result_t NO_RESULT = '0;
  localparam engine_result_t QUIET_OPEN =
    '{1'b0, 3'd0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1};
  localparam engine_result_t QUIET_FULL =
    '{1'b0, 3'd0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b0, 1'b1};

  localparam int unsigned N_DIRECTED = 21;

  // Directed events: empty-engine cases, window fill, full window, resend,
  // out-of-order frame, acks inside and outside the window, sequence wrap
  event_row_t directed_events [N_DIRECTED] = '{
    '{REQ_CSUM_ERR,   8'h00, 3'd0, 3'd0, 8'h00, 1'b1, QUIET_OPEN},
    '{REQ_TIMEOUT,    8'h00, 3'd0, 3'd0, 8'h00, 1'b1, QUIET_OPEN},
    '{REQ_FRAME,      8'h00, 3'd0, 3'd0, 8'hFF, 1'b1,
      '{1'b0, 3'd0, 3'd0, 8'h00, 1'b1, 8'hFF, 1'b1, 1'b1}},
    '{REQ_NEW_PACKET, 8'h00, 3'd0, 3'd0, 8'h00, 1'b1,
      '{1'b1, 3'd0, 3'd0, 8'h00, 1'b0, 8'h00, 1'b1, 1'b1}},
    '{REQ_NEW_PACKET, 8'hFF, 3'd0, 3'd0, 8'h00, 1'b0, NO_RESULT},
    '{REQ_NEW_PACKET, 8'h55, 3'd0, 3'd0, 8'h00, 1'b0, NO_RESULT},
    '{REQ_NEW_PACKET, 8'hAA, 3'd0, 3'd0, 8'h00, 1'b0, NO_RESULT},
    '{REQ_NEW_PACKET, 8'h01, 3'd0, 3'd0, 8'h00, 1'b0, NO_RESULT},
    '{REQ_NEW_PACKET, 8'h80, 3'd0, 3'd0, 8'h00, 1'b0, NO_RESULT},
    '{REQ_NEW_PACKET, 8'h7F, 3'd0, 3'd0, 8'h00, 1'b0, NO_RESULT},
    '{REQ_NEW_PACKET, 8'hEE, 3'd0, 3'd0, 8'h00, 1'b1, QUIET_FULL},
    '{REQ_CSUM_ERR,   8'hFF, 3'd7, 3'd7, 8'hFF, 1'b1, QUIET_FULL},
    '{REQ_TIMEOUT,    8'hFF, 3'd7, 3'd7, 8'hFF, 1'b0, NO_RESULT},
    '{REQ_FRAME,      8'h00, 3'd5, 3'd7, 8'h5A, 1'b0, NO_RESULT},
    '{REQ_FRAME,      8'h00, 3'd1, 3'd2, 8'hA5, 1'b0, NO_RESULT},
    '{REQ_FRAME,      8'h00, 3'd7, 3'd6, 8'h00, 1'b0, NO_RESULT},
    '{REQ_TIMEOUT,    8'h00, 3'd0, 3'd0, 8'h00, 1'b0, NO_RESULT},
    '{REQ_NEW_PACKET, 8'hC3, 3'd0, 3'd0, 8'h00, 1'b0, NO_RESULT},
    '{REQ_TIMEOUT,    8'h00, 3'd0, 3'd0, 8'h00, 1'b0, NO_RESULT},
    '{REQ_FRAME,      8'h00, 3'd2, 3'd7, 8'h3C, 1'b0, NO_RESULT},
    '{REQ_NEW_PACKET, 8'h96, 3'd0, 3'd0, 8'h00, 1'b0, NO_RESULT}
  };

  logic       clk_i;
  logic       rst_ni;
  logic       start;
  logic       busy;
  logic [1:0] req_type_i;
  logic [7:0] packet_byte_i;
  logic [2:0] rx_seq_i;
  logic [2:0] rx_ack_i;
  logic [7:0] rx_byte_i;
  logic       result_valid_o;
  logic       tx_valid_o;
  logic [2:0] tx_seq_o;
  logic [2:0] tx_ack_o;
  logic [7:0] tx_byte_o;
  logic       deliver_valid_o;
  logic [7:0] deliver_byte_o;
  logic       accept_new_o;
  logic       last_o;

  // Typed-in result travelling with the event on the pins
  logic           event_typed;
  engine_result_t event_want;

  // Window state as the engine should hold it
  seq_t  win_next;
  seq_t  win_oldest;
  seq_t  rx_expected;
  int    win_count;
  byte_t tx_store [STORE_DEPTH];

  engine_result_t awaited_results[$];
  int unsigned    fail_count;
  int unsigned    mismatch_count;
  int unsigned    cycle_count;

  go_back_n_window_engine_top uut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .req_type_i      (req_type_i),
    .packet_byte_i   (packet_byte_i),
    .rx_seq_i        (rx_seq_i),
    .rx_ack_i        (rx_ack_i),
    .rx_byte_i       (rx_byte_i),
    .result_valid_o  (result_valid_o),
    .tx_valid_o      (tx_valid_o),
    .tx_seq_o        (tx_seq_o),
    .tx_ack_o        (tx_ack_o),
    .tx_byte_o       (tx_byte_o),
    .deliver_valid_o (deliver_valid_o),
    .deliver_byte_o  (deliver_byte_o),
    .accept_new_o    (accept_new_o),
    .last_o          (last_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // Advance the window model by one event and queue the results it causes
  task automatic window_event(input req_e req, input byte_t pkt, input seq_t rseq,
                              input seq_t rack, input byte_t rbyte);
    engine_result_t r;
    engine_result_t batch[$];
    seq_t           ack_out;
    int             i;
    ack_out = seq_t'(rx_expected - 3'd1);
    r = '0;
    case (req)
      REQ_NEW_PACKET: begin
        // buffer and send, unless the window is full
        if (win_count < SEQ_MAX) begin
          tx_store[win_next] = pkt;
          win_count++;
          r.tx_valid = 1'b1;
          r.tx_seq   = win_next;
          r.tx_ack   = ack_out;
          r.tx_byte  = pkt;
          win_next   = seq_t'(win_next + 3'd1);
        end
        batch.push_back(r);
      end
      REQ_FRAME: begin
        // deliver only the in-order frame
        if (rseq == rx_expected) begin
          r.deliver_valid = 1'b1;
          r.deliver_byte  = rbyte;
          rx_expected     = seq_t'(rx_expected + 3'd1);
        end
        // release every frame up to and including the acked one
        while (win_count > 0 &&
               seq_t'(rack - win_oldest) < seq_t'(win_next - win_oldest)) begin
          win_count--;
          win_oldest = seq_t'(win_oldest + 3'd1);
        end
        batch.push_back(r);
      end
      REQ_TIMEOUT: begin
        // go back to the oldest frame and resend the whole window
        if (win_count > 0) begin
          win_next = win_oldest;
          for (i = 0; i < win_count; i++) begin
            r.tx_valid = 1'b1;
            r.tx_seq   = win_next;
            r.tx_ack   = ack_out;
            r.tx_byte  = tx_store[win_next];
            batch.push_back(r);
            win_next = seq_t'(win_next + 3'd1);
          end
        end else begin
          batch.push_back(r);
        end
      end
      default: batch.push_back(r);
    endcase
    foreach (batch[k]) begin
      batch[k].accept_new = (win_count < SEQ_MAX);
      batch[k].last       = (k == batch.size() - 1);
      awaited_results.push_back(batch[k]);
    end
  endtask

  function automatic void check_field(input string name, input logic [7:0] want,
                                      input logic [7:0] got);
    if (got !== want) begin
      mismatch_count++;
      fail_count++;
      if (mismatch_count <= MAX_REPORTS)
        $display("mismatch %s: expected %h, got %h at cycle %0d",
                 name, want, got, cycle_count);
    end
  endfunction

  // Check results, then record the transaction taken at this edge
  always @(posedge clk_i) begin
    engine_result_t want;
    if (rst_ni) begin
      if (result_valid_o) begin
        if (awaited_results.size() == 0) begin
          mismatch_count++;
          fail_count++;
          if (mismatch_count <= MAX_REPORTS)
            $display("unexpected result at cycle %0d", cycle_count);
        end else begin
          want = awaited_results.pop_front();
          check_field("tx_valid", 8'(want.tx_valid), 8'(tx_valid_o));
          check_field("tx_seq", 8'(want.tx_seq), 8'(tx_seq_o));
          check_field("tx_ack", 8'(want.tx_ack), 8'(tx_ack_o));
          check_field("tx_byte", want.tx_byte, tx_byte_o);
          check_field("deliver_valid", 8'(want.deliver_valid), 8'(deliver_valid_o));
          check_field("deliver_byte", want.deliver_byte, deliver_byte_o);
          check_field("accept_new", 8'(want.accept_new), 8'(accept_new_o));
          check_field("last", 8'(want.last), 8'(last_o));
        end
      end
      if (start && !busy) begin
        window_event(req_e'(req_type_i), packet_byte_i, rx_seq_i, rx_ack_i, rx_byte_i);
        if (event_typed) begin
          void'(awaited_results.pop_back());
          awaited_results.push_back(event_want);
        end
      end
    end
  end

  // Cycle watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Regression FAIL");
      $finish;
    end
  end

  // Present one event, optionally after an idle burst, and hold until taken
  task automatic send_event(input event_row_t row, input bit allow_idle);
    int gap;
    if (allow_idle && $urandom_range(0, 3) == 0) begin
      gap   = $urandom_range(1, 14);
      start = 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    start         = 1'b1;
    req_type_i    = row.req;
    packet_byte_i = row.pkt;
    rx_seq_i      = row.rseq;
    rx_ack_i      = row.rack;
    rx_byte_i     = row.rbyte;
    event_typed   = row.typed;
    event_want    = row.want;
    do @(posedge clk_i); while (busy);
    @(negedge clk_i);
  endtask

  // Hold off until every awaited result has come back
  task automatic drain_results();
    start = 1'b0;
    while (awaited_results.size() != 0) @(posedge clk_i);
    @(negedge clk_i);
  endtask

  // Build a random event, mostly a well-behaved peer with random payloads
  function automatic event_row_t random_event();
    event_row_t row;
    int         pick;
    row       = '0;
    row.pkt   = byte_t'($urandom);
    row.rseq  = seq_t'($urandom);
    row.rack  = seq_t'($urandom);
    row.rbyte = byte_t'($urandom);
    pick      = $urandom_range(0, 99);
    if (pick < 42) begin
      row.req = REQ_NEW_PACKET;
    end else if (pick < 82) begin
      row.req = REQ_FRAME;
      if ($urandom_range(0, 9) < 8)
        row.rseq = rx_expected;
      if (win_count > 0 && $urandom_range(0, 9) < 7)
        row.rack = seq_t'(win_oldest + $urandom_range(0, win_count - 1));
    end else if (pick < 90) begin
      row.req = REQ_CSUM_ERR;
    end else begin
      row.req = REQ_TIMEOUT;
    end
    return row;
  endfunction

  initial begin
    event_row_t  row;
    int unsigned counted;
    rst_ni         = 1'b0;
    start          = 1'b0;
    req_type_i     = REQ_CSUM_ERR;
    packet_byte_i  = '0;
    rx_seq_i       = '0;
    rx_ack_i       = '0;
    rx_byte_i      = '0;
    event_typed    = 1'b0;
    event_want     = '0;
    win_next       = '0;
    win_oldest     = '0;
    rx_expected    = '0;
    win_count      = 0;
    fail_count     = 0;
    mismatch_count = 0;
    cycle_count    = 0;
    counted        = 0;
    foreach (tx_store[k]) tx_store[k] = '0;

    repeat (2) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;
    @(negedge clk_i);

    // Directed events
    for (int i = 0; i < N_DIRECTED; i++)
      send_event(directed_events[i], 1'b1);
    drain_results();

    // Random events
    while (counted < RANDOM_EVENTS) begin
      row = random_event();
      counted++;
      send_event(row, counted < RANDOM_EVENTS - CALM_TAIL);
      if (counted % 50 == 0 && $urandom_range(0, 1) == 0)
        drain_results();
    end

    // Wind down
    drain_results();
    repeat (16) @(posedge clk_i);
    fail_count += awaited_results.size();
    if (fail_count == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

/* sim.f */
sv/gbn_pkg.sv
sv/gbn_ctrl.sv
sv/gbn_datapath.sv
sv/go_back_n_window_engine_top.sv
dv/tb_top.sv
